// ----- hdl/lrc_tsp_pkg.sv -----
package lrc_tsp_pkg;

  localparam int MAX_STAMPS = 32;
  localparam int STAMP_AW   = (MAX_STAMPS > 1) ? $clog2(MAX_STAMPS) : 1;
  localparam int COUNT_W    = $clog2(MAX_STAMPS + 1);
  localparam int STAMP_W    = 30;
  localparam int MSEC_W     = 31;
  localparam int MAC_W      = 32;
  localparam int MAC_PROD_W = 40;
  localparam int TEMP_W     = 20;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  localparam logic [13:0] FIELD_SAT   = 14'd9999;
  localparam logic [23:0] OFFSET_SAT  = 24'd9999999;
  localparam logic [3:0]  PREFIX_LEN  = 4'd7;
  localparam logic [3:0]  PREFIX_FAIL = 4'd8;
  localparam logic [3:0]  TAG_LEN_MAX = 4'd15;
  localparam logic [1:0]  FRAC_DIGITS = 2'd3;

  localparam logic [9:0] K_DECIMAL = 10'd10;
  localparam logic [9:0] K_MINUTE  = 10'd60;
  localparam logic [9:0] K_SECOND  = 10'd1000;
  localparam logic [9:0] K_UNIT    = 10'd1;

  typedef enum logic [1:0] {
    LP_TAG_START,
    LP_IN_TAG,
    LP_TEXT
  } line_phase_t;

  typedef enum logic [2:0] {
    SP_MINUTES,
    SP_SEC_FIRST,
    SP_SECONDS,
    SP_FRACTION,
    SP_NONE
  } stamp_phase_t;

  typedef enum logic [2:0] {
    MAC_FIELD,
    MAC_OFFSET,
    MAC_FRAC,
    MAC_MIN,
    MAC_MS,
    MAC_ADD
  } mac_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BYTE,
    S_CL_FRAC,
    S_CL_MIN,
    S_CL_MS,
    S_END,
    S_RD,
    S_ADD,
    S_MARK,
    S_FIN
  } state_t;

  typedef struct packed {
    mac_op_t                   op;
    logic [STAMP_W-1:0]        a;
    logic signed [MAC_W-1:0]   b;
  } mac_req_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0: c = 8'h6F;
      3'd1: c = 8'h66;
      3'd2: c = 8'h66;
      3'd3: c = 8'h73;
      3'd4: c = 8'h65;
      3'd5: c = 8'h74;
      3'd6: c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/lrc_tsp_mac.sv -----
module lrc_tsp_mac (
  input  lrc_tsp_pkg::mac_req_t           req,
  output logic [lrc_tsp_pkg::MAC_W-1:0]   res
);
  import lrc_tsp_pkg::*;

  logic [9:0]            k;
  logic [MAC_PROD_W-1:0] prod;
  logic [MAC_PROD_W-1:0] sum;

  always_comb begin
    unique case (req.op)
      MAC_FIELD, MAC_OFFSET, MAC_FRAC: k = K_DECIMAL;
      MAC_MIN: k = K_MINUTE;
      MAC_MS:  k = K_SECOND;
      default: k = K_UNIT;
    endcase
  end

  assign prod = {{(MAC_PROD_W-STAMP_W){1'b0}}, req.a} * {{(MAC_PROD_W-10){1'b0}}, k};
  assign sum  = prod + {{(MAC_PROD_W-MAC_W){req.b[MAC_W-1]}}, req.b};

  always_comb begin
    res = sum[MAC_W-1:0];
    unique case (req.op)
      MAC_FIELD: begin
        if (sum > MAC_PROD_W'(FIELD_SAT)) res = MAC_W'(FIELD_SAT);
      end
      MAC_OFFSET: begin
        if (sum > MAC_PROD_W'(OFFSET_SAT)) res = MAC_W'(OFFSET_SAT);
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/lrc_tag_timestamp_parser.sv -----
// LRC timestamp tag parser. Feed lyric text one byte per beat on s_*; s_tlast marks
// end of text, ends the line and clears the running offset. At each line end that
// holds non-blank text, one beat per stored [m:ss.fff] stamp leaves on m_* with the
// offset from an [offset:+/-N] tag added, m_tlast on the final one; with cfg_wdata
// written 0 an untimed text line yields one beat with m_tuser set. An ordinary byte
// passes from S_IDLE through S_BYTE. A ']' that closes a timestamp adds a state for
// each step of the shared multiply-add unit (fraction padding, minutes*60, *1000). A
// line end passes S_END, S_RD and S_ADD per stamp beat or S_MARK for the unsynced
// beat, then S_FIN; S_ADD and S_MARK wait until m_tready takes a held beat.
// The stamp store is a memory read one entry per beat. s_tready is low while busy.
module lrc_tag_timestamp_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic        cfg_wdata,   // synced_mode
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // [7:0] ch
  input  logic        s_tlast,     // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,     // [30:0] msec, [31] zero
  output logic        m_tuser,     // unsynced
  output logic        m_tlast      // last
);
  import lrc_tsp_pkg::*;

  state_t       state, state_next;
  logic [7:0]   ch_r;
  logic         eot_r;
  logic         synced_mode;
  line_phase_t  line_phase;
  stamp_phase_t stamp_phase;
  logic [13:0]  minutes_acc;
  logic [13:0]  seconds_acc;
  logic [9:0]   fraction_acc;
  logic [1:0]   fraction_digits;
  logic [3:0]   tag_length;
  logic [3:0]   prefix_matched;
  logic         offset_negative;
  logic [23:0]  offset_accum;
  logic         offset_digits_done;
  logic signed [24:0] offset_ms;
  logic [COUNT_W-1:0] stamp_count;
  logic [COUNT_W-1:0] idx;
  logic         text_seen;
  logic [TEMP_W-1:0]  temp;
  logic [STAMP_W-1:0] stamp_mem [MAX_STAMPS];
  logic [STAMP_W-1:0] rd_data;
  logic [MSEC_W-1:0]  out_msec;
  logic         out_unsynced;
  logic         out_last;

  mac_req_t         mac_req;
  logic [MAC_W-1:0] mac_res;

  logic       is_digit;
  logic [3:0] digit;
  logic [7:0] lc;
  logic       is_blank;
  logic       out_free;
  logic       line_text;
  logic       stamp_close;
  logic       mem_we;

  lrc_tsp_mac u_mac (
    .req (mac_req),
    .res (mac_res)
  );

  assign is_digit    = (ch_r >= CH_ZERO) && (ch_r <= CH_NINE);
  assign digit       = 4'(ch_r - CH_ZERO);
  assign lc          = ((ch_r >= CH_UPPER_A) && (ch_r <= CH_UPPER_Z)) ? ch_r + CASE_DELTA : ch_r;
  assign is_blank    = (ch_r == CH_SPACE) || (ch_r == CH_TAB) || (ch_r == CH_CR);
  assign out_free    = !m_tvalid || m_tready;
  assign line_text   = text_seen || (line_phase == LP_IN_TAG);
  assign stamp_close = (line_phase == LP_IN_TAG) && (ch_r == CH_RBRACK) &&
                       ((stamp_phase == SP_SECONDS) || (stamp_phase == SP_FRACTION));
  assign mem_we      = (state == S_CL_MS);

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {1'b0, out_msec};
  assign m_tuser  = out_unsynced;
  assign m_tlast  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mac_req.op = MAC_ADD;
    mac_req.a  = '0;
    mac_req.b  = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_BYTE;
      end
      S_BYTE: begin
        mac_req.b = MAC_W'(digit);
        priority if (stamp_phase == SP_MINUTES) begin
          mac_req.op = MAC_FIELD;
          mac_req.a  = STAMP_W'(minutes_acc);
        end else if (stamp_phase == SP_SEC_FIRST || stamp_phase == SP_SECONDS) begin
          mac_req.op = MAC_FIELD;
          mac_req.a  = STAMP_W'(seconds_acc);
        end else if (stamp_phase == SP_FRACTION) begin
          mac_req.op = MAC_FRAC;
          mac_req.a  = STAMP_W'(fraction_acc);
        end else begin
          mac_req.op = MAC_OFFSET;
          mac_req.a  = STAMP_W'(offset_accum);
        end
        priority if (ch_r == CH_NL) begin
          state_next = S_END;
        end else if (stamp_close && stamp_count < COUNT_W'(MAX_STAMPS)) begin
          state_next = (fraction_digits < FRAC_DIGITS) ? S_CL_FRAC : S_CL_MIN;
        end else if (eot_r) begin
          state_next = S_END;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CL_FRAC: begin
        mac_req.op = MAC_FRAC;
        mac_req.a  = STAMP_W'(fraction_acc);
        if (fraction_digits == FRAC_DIGITS - 2'd1) state_next = S_CL_MIN;
      end
      S_CL_MIN: begin
        mac_req.op = MAC_MIN;
        mac_req.a  = STAMP_W'(minutes_acc);
        mac_req.b  = MAC_W'(seconds_acc);
        state_next = S_CL_MS;
      end
      S_CL_MS: begin
        mac_req.op = MAC_MS;
        mac_req.a  = STAMP_W'(temp);
        mac_req.b  = MAC_W'(fraction_acc);
        state_next = eot_r ? S_END : S_IDLE;
      end
      S_END: begin
        priority if (line_text && stamp_count != '0) begin
          state_next = S_RD;
        end else if (line_text && !synced_mode) begin
          state_next = S_MARK;
        end else begin
          state_next = S_FIN;
        end
      end
      S_RD: begin
        state_next = S_ADD;
      end
      S_ADD: begin
        mac_req.op = MAC_ADD;
        mac_req.a  = rd_data;
        mac_req.b  = MAC_W'(offset_ms);
        if (out_free) state_next = (idx + 1'b1 == stamp_count) ? S_FIN : S_RD;
      end
      S_MARK: begin
        if (out_free) state_next = S_FIN;
      end
      S_FIN: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ch_r  <= s_tdata;
      eot_r <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) stamp_mem[stamp_count[STAMP_AW-1:0]] <= mac_res[STAMP_W-1:0];
    if (state == S_RD) rd_data <= stamp_mem[idx[STAMP_AW-1:0]];
    if (state == S_CL_MIN) temp <= mac_res[TEMP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      synced_mode        <= 1'b1;
      line_phase         <= LP_TAG_START;
      stamp_phase        <= SP_MINUTES;
      minutes_acc        <= '0;
      seconds_acc        <= '0;
      fraction_acc       <= '0;
      fraction_digits    <= '0;
      tag_length         <= '0;
      prefix_matched     <= '0;
      offset_negative    <= 1'b0;
      offset_accum       <= '0;
      offset_digits_done <= 1'b0;
      offset_ms          <= '0;
      stamp_count        <= '0;
      text_seen          <= 1'b0;
      idx                <= '0;
      m_tvalid           <= 1'b0;
    end else begin
      if (cfg_wen) synced_mode <= cfg_wdata;
      if ((state == S_ADD || state == S_MARK) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_BYTE: begin
          if (ch_r != CH_NL && ch_r != CH_NUL) begin
            unique case (line_phase)
              LP_TAG_START: begin
                if (ch_r == CH_LBRACK) begin
                  line_phase         <= LP_IN_TAG;
                  stamp_phase        <= SP_MINUTES;
                  minutes_acc        <= '0;
                  seconds_acc        <= '0;
                  fraction_acc       <= '0;
                  fraction_digits    <= '0;
                  tag_length         <= '0;
                  prefix_matched     <= '0;
                  offset_negative    <= 1'b0;
                  offset_accum       <= '0;
                  offset_digits_done <= 1'b0;
                end else begin
                  line_phase <= LP_TEXT;
                  if (!is_blank) text_seen <= 1'b1;
                end
              end
              LP_IN_TAG: begin
                if (ch_r == CH_RBRACK) begin
                  line_phase <= LP_TAG_START;
                  if (!stamp_close && prefix_matched == PREFIX_LEN &&
                      tag_length > PREFIX_LEN) begin
                    offset_ms <= offset_negative ? -$signed({1'b0, offset_accum})
                                                 : $signed({1'b0, offset_accum});
                  end
                end else begin
                  unique case (stamp_phase)
                    SP_MINUTES: begin
                      priority if (is_digit) minutes_acc <= mac_res[13:0];
                      else if (ch_r == CH_COLON) stamp_phase <= SP_SEC_FIRST;
                      else stamp_phase <= SP_NONE;
                    end
                    SP_SEC_FIRST: begin
                      if (is_digit) begin
                        seconds_acc <= mac_res[13:0];
                        stamp_phase <= SP_SECONDS;
                      end else begin
                        stamp_phase <= SP_NONE;
                      end
                    end
                    SP_SECONDS: begin
                      priority if (is_digit) seconds_acc <= mac_res[13:0];
                      else if (ch_r == CH_DOT) stamp_phase <= SP_FRACTION;
                      else stamp_phase <= SP_NONE;
                    end
                    SP_FRACTION: begin
                      if (is_digit) begin
                        if (fraction_digits < FRAC_DIGITS) begin
                          fraction_acc    <= mac_res[9:0];
                          fraction_digits <= fraction_digits + 2'd1;
                        end
                      end else begin
                        stamp_phase <= SP_NONE;
                      end
                    end
                    default: ;
                  endcase
                  if (tag_length < PREFIX_LEN) begin
                    if (prefix_matched == tag_length && lc == prefix_char(tag_length[2:0])) begin
                      prefix_matched <= prefix_matched + 4'd1;
                    end else begin
                      prefix_matched <= PREFIX_FAIL;
                    end
                  end else if (prefix_matched == PREFIX_LEN) begin
                    priority if (tag_length == PREFIX_LEN &&
                                 (ch_r == CH_PLUS || ch_r == CH_MINUS)) begin
                      offset_negative <= (ch_r == CH_MINUS);
                    end else if (!offset_digits_done && is_digit) begin
                      offset_accum <= mac_res[23:0];
                    end else begin
                      offset_digits_done <= 1'b1;
                    end
                  end
                  if (tag_length < TAG_LEN_MAX) tag_length <= tag_length + 4'd1;
                end
              end
              LP_TEXT: begin
                if (!is_blank) text_seen <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_CL_FRAC: begin
          fraction_acc    <= mac_res[9:0];
          fraction_digits <= fraction_digits + 2'd1;
        end
        S_CL_MS: begin
          stamp_count <= stamp_count + 1'b1;
        end
        S_END: begin
          idx <= '0;
        end
        S_ADD: begin
          if (out_free) begin
            out_msec     <= mac_res[MSEC_W-1:0];
            out_unsynced <= 1'b0;
            out_last     <= (idx + 1'b1 == stamp_count);
            idx          <= idx + 1'b1;
          end
        end
        S_MARK: begin
          if (out_free) begin
            out_msec     <= '0;
            out_unsynced <= 1'b1;
            out_last     <= 1'b1;
          end
        end
        S_FIN: begin
          line_phase         <= LP_TAG_START;
          stamp_count        <= '0;
          text_seen          <= 1'b0;
          stamp_phase        <= SP_MINUTES;
          minutes_acc        <= '0;
          seconds_acc        <= '0;
          fraction_acc       <= '0;
          fraction_digits    <= '0;
          tag_length         <= '0;
          prefix_matched     <= '0;
          offset_negative    <= 1'b0;
          offset_accum       <= '0;
          offset_digits_done <= 1'b0;
          if (eot_r) offset_ms <= '0;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    stamp_count <= COUNT_W'(MAX_STAMPS))
    else $error("stamp count beyond store depth");

  a_store_room: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> stamp_count < COUNT_W'(MAX_STAMPS))
    else $error("stamp write into full store");

  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0 && m_tlast)
    else $error("unsynced beat with nonzero time or without last");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while previous byte in flight");
`endif

endmodule
